FILE: src/smb_pkg.sv
// package for the soil moisture bucket step
// holds field widths, the item record types, saturation helper and the exp(-x) table
// no dependencies
package smb_pkg;

   localparam int MM_W = 23;
   localparam int VAL_W = 24;
   localparam int WIDE_W = 27;
   localparam int FRAC_W = 16;
   localparam int RAIN_W = 17;
   localparam int ALPHA_W = 12;
   localparam int Q30_W = 31;
   localparam int EXP_DEPTH = 256;
   localparam int EXP_IDX_W = $clog2(EXP_DEPTH);
   localparam int EXP_ADR_W = $clog2(EXP_DEPTH + 1);
   localparam int EXP_X_W = 21;
   localparam int EXP_FRAC_W = 20;

   localparam logic signed [WIDE_W-1:0] WIDE_VMAX = 27'sd8388607;
   localparam logic signed [WIDE_W-1:0] WIDE_VMIN = -27'sd8388608;
   localparam logic [Q30_W-1:0] Q30_ONE = 31'h4000_0000;
   localparam logic [ALPHA_W-1:0] ALPHA_RESET = 12'd1280;

   // exp(-step) in q0.30 as a truncated 13-term series
   localparam longint unsigned EXP_STEP_Q30 = (64'd16 << 30) / EXP_DEPTH;
   localparam longint unsigned EXP_T0  = 64'd1 << 30;
   localparam longint unsigned EXP_T1  = (EXP_T0 * EXP_STEP_Q30) >> 30;
   localparam longint unsigned EXP_T2  = ((EXP_T1 * EXP_STEP_Q30) >> 30) / 2;
   localparam longint unsigned EXP_T3  = ((EXP_T2 * EXP_STEP_Q30) >> 30) / 3;
   localparam longint unsigned EXP_T4  = ((EXP_T3 * EXP_STEP_Q30) >> 30) / 4;
   localparam longint unsigned EXP_T5  = ((EXP_T4 * EXP_STEP_Q30) >> 30) / 5;
   localparam longint unsigned EXP_T6  = ((EXP_T5 * EXP_STEP_Q30) >> 30) / 6;
   localparam longint unsigned EXP_T7  = ((EXP_T6 * EXP_STEP_Q30) >> 30) / 7;
   localparam longint unsigned EXP_T8  = ((EXP_T7 * EXP_STEP_Q30) >> 30) / 8;
   localparam longint unsigned EXP_T9  = ((EXP_T8 * EXP_STEP_Q30) >> 30) / 9;
   localparam longint unsigned EXP_T10 = ((EXP_T9 * EXP_STEP_Q30) >> 30) / 10;
   localparam longint unsigned EXP_T11 = ((EXP_T10 * EXP_STEP_Q30) >> 30) / 11;
   localparam longint unsigned EXP_T12 = ((EXP_T11 * EXP_STEP_Q30) >> 30) / 12;
   localparam longint unsigned EXP_STEP_FACTOR = EXP_T0 - EXP_T1 + EXP_T2 - EXP_T3 + EXP_T4
                                                 - EXP_T5 + EXP_T6 - EXP_T7 + EXP_T8 - EXP_T9
                                                 + EXP_T10 - EXP_T11 + EXP_T12;

   typedef logic [Q30_W-1:0] exp_tab_type [0:EXP_DEPTH];

   typedef struct packed {
      logic [MM_W-1:0]          precip;
      logic [MM_W-1:0]          pet;
      logic signed [VAL_W-1:0]  snow_chg;
      logic [MM_W-1:0]          icpt;
      logic [MM_W-1:0]          cap;
      logic [RAIN_W-1:0]        r;
      logic [MM_W-1:0]          s;
      logic                     cap_zero;
      logic                     snow_on;
   } cell_type;

   typedef struct packed {
      cell_type                 grid;
      logic [MM_W-1:0]          petr;
      logic                     surplus;
      logic [VAL_W-1:0]         mag;
      logic signed [VAL_W:0]    chg_sur;
   } work_type;

   function automatic exp_tab_type build_exp_tab();
      exp_tab_type t;
      longint unsigned prev;
      prev = 64'd1 << 30;
      t[0] = Q30_ONE;
      for (int i = 1; i <= EXP_DEPTH; i++) begin
         prev = (prev * EXP_STEP_FACTOR + (64'd1 << 29)) >> 30;
         t[i] = prev[Q30_W-1:0];
      end
      return t;
   endfunction

   localparam exp_tab_type EXP_TAB = build_exp_tab();

   function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [WIDE_W-1:0] v);
      logic signed [WIDE_W-1:0] c;
      c = v;
      if (v > WIDE_VMAX) c = WIDE_VMAX;
      if (v < WIDE_VMIN) c = WIDE_VMIN;
      return c[VAL_W-1:0];
   endfunction

endpackage

FILE: src/smb_div.sv
// pipelined restoring divider, one quotient bit per stage, with side payload
// uses no package
module smb_div #(
   parameter int NW = 39,
   parameter int DW = 17,
   parameter int PW = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_vld,
   input  logic [NW-1:0] in_num,
   input  logic [DW-1:0] in_den,
   input  logic [PW-1:0] in_pl,
   output logic          out_vld,
   output logic [NW-1:0] out_quot,
   output logic [PW-1:0] out_pl
);

   logic [NW-1:0] nq_ff  [0:NW-1];
   logic [DW-1:0] rem_ff [0:NW-1];
   logic [DW-1:0] den_ff [0:NW-1];
   logic [PW-1:0] pl_ff  [0:NW-1];
   logic          vld_ff [0:NW-1];

   for (genvar k = 0; k < NW; k++) begin : g_stage
      logic [NW-1:0] nq_src;
      logic [DW-1:0] rem_src;
      logic [DW-1:0] den_src;
      logic [PW-1:0] pl_src;
      logic          vld_src;
      logic [DW:0]   trial;
      logic [DW:0]   diff;
      logic          take;

      if (k == 0) begin : g_first
         assign nq_src  = in_num;
         assign rem_src = '0;
         assign den_src = in_den;
         assign pl_src  = in_pl;
         assign vld_src = in_vld;
      end else begin : g_next
         assign nq_src  = nq_ff[k-1];
         assign rem_src = rem_ff[k-1];
         assign den_src = den_ff[k-1];
         assign pl_src  = pl_ff[k-1];
         assign vld_src = vld_ff[k-1];
      end

      assign trial = {rem_src, nq_src[NW-1]};
      assign take  = trial >= {1'b0, den_src};
      assign diff  = trial - {1'b0, den_src};

      always_ff @(posedge clock) begin
         nq_ff[k]  <= {nq_src[NW-2:0], take};
         rem_ff[k] <= take ? diff[DW-1:0] : trial[DW-1:0];
         den_ff[k] <= den_src;
         pl_ff[k]  <= pl_src;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else begin
            vld_ff[k] <= vld_src;
         end
      end
   end

   assign out_vld  = vld_ff[NW-1];
   assign out_quot = nq_ff[NW-1];
   assign out_pl   = pl_ff[NW-1];

endmodule

FILE: src/smb_exp.sv
// two-stage exp(-x) unit: table lookup then linear interpolation, Q1.30 result
// depends on smb_pkg for the table
module smb_exp
   import smb_pkg::*;
(
   input  logic               clock,
   input  logic [EXP_X_W-1:0] x,
   output logic [Q30_W-1:0]   e
);

   localparam int POS_W = EXP_FRAC_W + EXP_IDX_W;

   logic [POS_W-1:0]      pos;
   logic [EXP_ADR_W-1:0]  idx;
   logic [Q30_W-1:0]      t0_in, t1_in;
   logic [EXP_FRAC_W-1:0] frac_in;
   logic [Q30_W-1:0]      t0_ff, diff_ff, e_ff;
   logic [EXP_FRAC_W-1:0] frac_ff;
   logic [Q30_W+EXP_FRAC_W-1:0] prod;

   always_comb begin
      pos = POS_W'(x[EXP_X_W-2:0]) * POS_W'(EXP_DEPTH);
      idx = EXP_ADR_W'(pos[POS_W-1:EXP_FRAC_W]);
      if (x[EXP_X_W-1]) begin
         t0_in   = EXP_TAB[EXP_DEPTH];
         t1_in   = EXP_TAB[EXP_DEPTH];
         frac_in = '0;
      end else begin
         t0_in   = EXP_TAB[idx];
         t1_in   = EXP_TAB[idx + 1'b1];
         frac_in = pos[EXP_FRAC_W-1:0];
      end
   end

   assign prod = (Q30_W+EXP_FRAC_W)'(diff_ff) * (Q30_W+EXP_FRAC_W)'(frac_ff);

   always_ff @(posedge clock) begin
      t0_ff   <= t0_in;
      diff_ff <= t0_in - t1_in;
      frac_ff <= frac_in;
      e_ff    <= t0_ff - prod[Q30_W+EXP_FRAC_W-1:EXP_FRAC_W];
   end

   assign e = e_ff;

endmodule

FILE: src/smb_fifo.sv
// small register queue between the front and back parts
// uses no package
module smb_fifo #(
   parameter int W = 8,
   parameter int DEPTH = 2
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  logic [W-1:0] wdata,
   input  logic         pop,
   output logic [W-1:0] rdata,
   output logic         empty,
   output logic         full
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [W-1:0]     mem_ff [0:DEPTH-1];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign empty   = cnt_ff == '0;
   assign full    = cnt_ff == CNT_W'(DEPTH);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

FILE: src/smb_front.sv
// front part: takes a cell, classifies it and unscales the stored moisture
// depends on smb_pkg and smb_div
module smb_front
   import smb_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  logic [MM_W-1:0]         precipitation,
   input  logic [MM_W-1:0]         potential_et,
   input  logic signed [VAL_W-1:0] snow_pack_change,
   input  logic [MM_W-1:0]         snow_pack,
   input  logic [MM_W-1:0]         interception,
   input  logic [MM_W-1:0]         stored_moisture,
   input  logic [MM_W-1:0]         water_capacity,
   input  logic [FRAC_W-1:0]       irrigated_fraction,
   output logic                    push,
   output cell_type                grid
);

   localparam int SNUM_W = MM_W + FRAC_W;

   cell_type          cell_ff, cell_in, cell_out;
   logic [MM_W-1:0]   stored_ff;
   logic              vld_ff;
   logic [SNUM_W-1:0] quot;

   always_comb begin
      cell_in          = '0;
      cell_in.precip   = precipitation;
      cell_in.pet      = potential_et;
      cell_in.snow_chg = snow_pack_change;
      cell_in.icpt     = interception;
      cell_in.cap      = water_capacity;
      cell_in.r        = RAIN_W'(17'h10000 - {1'b0, irrigated_fraction});
      cell_in.cap_zero = water_capacity == '0;
      cell_in.snow_on  = snow_pack != '0;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cell_ff   <= cell_in;
         stored_ff <= stored_moisture;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= accept;
      end
   end

   smb_div #(.NW(SNUM_W), .DW(RAIN_W), .PW($bits(cell_type))) u_sdiv (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (vld_ff),
      .in_num   ({stored_ff, {FRAC_W{1'b0}}}),
      .in_den   (cell_ff.r),
      .in_pl    (cell_ff),
      .out_vld  (push),
      .out_quot (quot),
      .out_pl   (cell_out)
   );

   always_comb begin
      grid = cell_out;
      grid.s = (quot > SNUM_W'(WIDE_VMAX)) ? MM_W'(WIDE_VMAX) : quot[MM_W-1:0];
   end

endmodule

FILE: src/smb_back.sv
// back part: bucket fill or exponential drying, evapotranspiration, rainfed scaling
// depends on smb_pkg, smb_div and smb_exp
module smb_back
   import smb_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic [ALPHA_W-1:0]       alpha,
   input  logic                     pop,
   input  cell_type                 grid,
   output logic                     rsp_strobe,
   output logic signed [VAL_W-1:0]  rsp_actual_et,
   output logic [MM_W-1:0]          rsp_new_moisture,
   output logic signed [VAL_W-1:0]  rsp_moisture_change
);

   localparam int QN_W = MM_W + FRAC_W;
   localparam int QC_W = 29;
   localparam int AP_W = QC_W + ALPHA_W;
   localparam int MN_W = VAL_W + Q30_W;
   localparam int SP_W = VAL_W + RAIN_W;

   // stage 1: classify surplus or deficit
   work_type b1_in, b1_ff;
   logic     b1_vld_ff;
   logic signed [WIDE_W-1:0] p27, sc27, i27, cap27, s27, win27, petr27, d27, room27, chs27;
   logic signed [VAL_W-1:0]  win;
   logic [MM_W-1:0]          petr;

   always_comb begin
      p27    = signed'({4'b0, grid.precip});
      sc27   = WIDE_W'(grid.snow_chg);
      i27    = signed'({4'b0, grid.icpt});
      cap27  = signed'({4'b0, grid.cap});
      s27    = signed'({4'b0, grid.s});
      win    = sat_val(p27 - sc27 - i27);
      petr   = (grid.pet > grid.icpt) ? grid.pet - grid.icpt : '0;
      win27  = WIDE_W'(win);
      petr27 = signed'({4'b0, petr});
      d27    = win27 - petr27;
      room27 = cap27 - s27;
      chs27  = (d27 > room27) ? room27 : d27;
      b1_in         = '0;
      b1_in.grid    = grid;
      b1_in.petr    = petr;
      b1_in.surplus = win27 > petr27;
      b1_in.mag     = VAL_W'(petr27 - win27);
      b1_in.chg_sur = (VAL_W+1)'(chs27);
   end

   always_ff @(posedge clock) begin
      b1_ff <= b1_in;
   end

   // ratio s/cap in q.16
   logic            q_vld;
   logic [QN_W-1:0] q16;
   work_type        q_wk;

   smb_div #(.NW(QN_W), .DW(MM_W), .PW($bits(work_type))) u_qdiv (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (b1_vld_ff),
      .in_num   ({b1_ff.grid.s, {FRAC_W{1'b0}}}),
      .in_den   (b1_ff.grid.cap),
      .in_pl    (b1_ff),
      .out_vld  (q_vld),
      .out_quot (q16),
      .out_pl   (q_wk)
   );

   // stage 2: alpha times ratio
   logic [QC_W-1:0] qc;
   logic [AP_W-1:0] ap_ff;
   work_type        b2_ff;
   logic            b2_vld_ff;

   assign qc = (q16 >= QN_W'(1 << (QC_W - 1))) ? QC_W'(1 << (QC_W - 1)) : q16[QC_W-1:0];

   always_ff @(posedge clock) begin
      ap_ff <= AP_W'(qc) * AP_W'(alpha);
      b2_ff <= q_wk;
   end

   // exp lookup, with the payload held in b3a_ff and b3b_ff
   logic [EXP_X_W-1:0] xe;
   logic [Q30_W-1:0]   e_num, e_den;
   work_type           b3a_ff, b3b_ff;
   logic               b3a_vld_ff, b3b_vld_ff;

   assign xe = (ap_ff[AP_W-1:8] >= (AP_W-8)'(1 << (EXP_X_W - 1))) ?
               EXP_X_W'(1 << (EXP_X_W - 1)) : EXP_X_W'(ap_ff[EXP_X_W+6:8]);

   smb_exp u_exp_num (
      .clock (clock),
      .x     (xe),
      .e     (e_num)
   );

   smb_exp u_exp_den (
      .clock (clock),
      .x     ({1'b0, alpha, 8'h00}),
      .e     (e_den)
   );

   logic [Q30_W-1:0] den_ff, den_in;

   always_comb begin
      den_in = Q30_ONE - e_den;
      if (den_in == '0) begin
         den_in = Q30_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      den_ff <= den_in;
      b3a_ff <= b2_ff;
      b3b_ff <= b3a_ff;
   end

   // stage 4: deficit times (1 - e)
   logic [MN_W-1:0] mn_ff;
   work_type        b4_ff;
   logic            b4_vld_ff;

   always_ff @(posedge clock) begin
      mn_ff <= MN_W'(b3b_ff.mag) * MN_W'(Q30_ONE - e_num);
      b4_ff <= b3b_ff;
   end

   logic            m_vld;
   logic [MN_W-1:0] mq;
   work_type        m_wk;

   smb_div #(.NW(MN_W), .DW(Q30_W), .PW($bits(work_type))) u_mdiv (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (b4_vld_ff),
      .in_num   (mn_ff),
      .in_den   (den_ff),
      .in_pl    (b4_ff),
      .out_vld  (m_vld),
      .out_quot (mq),
      .out_pl   (m_wk)
   );

   // stage 5: final change, moisture and evapotranspiration
   logic signed [WIDE_W-1:0] mp27, msc27, mi27, mcap27, ms27, cd1, cd2, chg27;
   logic signed [VAL_W-1:0]  chg_in, dem, avail, et_in;
   logic [MM_W-1:0]          s_in, pet_used;
   logic signed [VAL_W-1:0]  chg_ff, et_ff;
   logic [MM_W-1:0]          s_ff;
   logic [RAIN_W-1:0]        r5_ff;
   logic                     b5_vld_ff;

   always_comb begin
      mp27   = signed'({4'b0, m_wk.grid.precip});
      msc27  = WIDE_W'(m_wk.grid.snow_chg);
      mi27   = signed'({4'b0, m_wk.grid.icpt});
      mcap27 = signed'({4'b0, m_wk.grid.cap});
      ms27   = signed'({4'b0, m_wk.grid.s});
      if (mq >= MN_W'(1 << MM_W)) begin
         cd1 = WIDE_VMIN;
      end else begin
         cd1 = -signed'({4'b0, mq[MM_W-1:0]});
      end
      cd2 = cd1;
      if (ms27 + cd1 > mcap27) begin
         cd2 = mcap27 - ms27;
      end
      if (ms27 + cd2 < 0) begin
         cd2 = -ms27;
      end
      chg27 = m_wk.surplus ? WIDE_W'(m_wk.chg_sur) : cd2;
      chg_in = sat_val(chg27);
      s_in = MM_W'(ms27 + WIDE_W'(chg_in));
      pet_used = m_wk.petr;
      if (m_wk.grid.cap_zero) begin
         chg_in = '0;
         s_in = '0;
         pet_used = m_wk.grid.pet;
      end else if (m_wk.grid.snow_on) begin
         chg_in = '0;
         s_in = m_wk.grid.s;
         pet_used = m_wk.grid.pet;
      end
      dem   = sat_val(signed'({4'b0, pet_used}) + mi27);
      avail = sat_val(mp27 - msc27 - WIDE_W'(chg_in));
      et_in = (dem < avail) ? dem : avail;
   end

   always_ff @(posedge clock) begin
      chg_ff <= chg_in;
      et_ff  <= et_in;
      s_ff   <= s_in;
      r5_ff  <= m_wk.grid.r;
   end

   // stage 6: rainfed scaling products
   logic [VAL_W-1:0] et_mag, chg_mag;
   logic [SP_W-1:0]  pet6_ff, ps6_ff, pchg6_ff;
   logic             et_neg_ff, chg_neg_ff, b6_vld_ff;

   assign et_mag  = et_ff[VAL_W-1] ? VAL_W'(-et_ff) : VAL_W'(et_ff);
   assign chg_mag = chg_ff[VAL_W-1] ? VAL_W'(-chg_ff) : VAL_W'(chg_ff);

   always_ff @(posedge clock) begin
      pet6_ff    <= SP_W'(et_mag) * SP_W'(r5_ff);
      ps6_ff     <= SP_W'(s_ff) * SP_W'(r5_ff);
      pchg6_ff   <= SP_W'(chg_mag) * SP_W'(r5_ff);
      et_neg_ff  <= et_ff[VAL_W-1];
      chg_neg_ff <= chg_ff[VAL_W-1];
   end

   // stage 7: output word
   logic [VAL_W-1:0]        pe, pc;
   logic signed [VAL_W-1:0] et_out_ff, chg_out_ff;
   logic [MM_W-1:0]         nm_out_ff;
   logic                    b7_vld_ff;

   assign pe = pet6_ff[FRAC_W+VAL_W-1:FRAC_W];
   assign pc = pchg6_ff[FRAC_W+VAL_W-1:FRAC_W];

   always_ff @(posedge clock) begin
      et_out_ff  <= et_neg_ff ? signed'(VAL_W'(-pe)) : signed'(pe);
      chg_out_ff <= chg_neg_ff ? signed'(VAL_W'(-pc)) : signed'(pc);
      nm_out_ff  <= ps6_ff[FRAC_W+MM_W-1:FRAC_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_vld_ff  <= 1'b0;
         b2_vld_ff  <= 1'b0;
         b3a_vld_ff <= 1'b0;
         b3b_vld_ff <= 1'b0;
         b4_vld_ff  <= 1'b0;
         b5_vld_ff  <= 1'b0;
         b6_vld_ff  <= 1'b0;
         b7_vld_ff  <= 1'b0;
      end else begin
         b1_vld_ff  <= pop;
         b2_vld_ff  <= q_vld;
         b3a_vld_ff <= b2_vld_ff;
         b3b_vld_ff <= b3a_vld_ff;
         b4_vld_ff  <= b3b_vld_ff;
         b5_vld_ff  <= m_vld;
         b6_vld_ff  <= b5_vld_ff;
         b7_vld_ff  <= b6_vld_ff;
      end
   end

   assign rsp_strobe          = b7_vld_ff;
   assign rsp_actual_et       = et_out_ff;
   assign rsp_new_moisture    = nm_out_ff;
   assign rsp_moisture_change = chg_out_ff;

endmodule

FILE: src/soil_moisture_bucket_step.sv
// soil moisture bucket step, one grid cell per word
// top level: drying shape register, front part, queue and back part
// depends on smb_pkg, smb_front, smb_fifo and smb_back
//
// usage
//   input: a cell word is taken at a rising edge with start high and busy low;
//   all req_ fields are sampled at that edge. busy stays low in normal flow, so
//   a new cell may be given in every cycle.
//   output: each cell gives one result word on the rsp_ ports, marked by
//   rsp_strobe for exactly one cycle; the receiver has no way to hold it off.
//   configuration: csr_we with csr_wdata writes the 12-bit drying shape
//   (unsigned Q4.8); write it only while no cells are in flight.
//   path: a cell passes the front input register, the three pipelined
//   restoring dividers (unscaling, moisture ratio and drying factor) and the
//   queue, lookup and scaling stages before rsp_strobe rises for it.
//   throughput: one cell per cycle while busy is low, in order.
//   reset: synchronous, active high; empties the pipeline and the queue and
//   sets the drying shape to 5.0.
module soil_moisture_bucket_step
   import smb_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [MM_W-1:0]         req_precipitation,
   input  logic [MM_W-1:0]         req_potential_et,
   input  logic signed [VAL_W-1:0] req_snow_pack_change,
   input  logic [MM_W-1:0]         req_snow_pack,
   input  logic [MM_W-1:0]         req_interception,
   input  logic [MM_W-1:0]         req_stored_moisture,
   input  logic [MM_W-1:0]         req_water_capacity,
   input  logic [FRAC_W-1:0]       req_irrigated_fraction,
   input  logic                    csr_we,
   input  logic [ALPHA_W-1:0]      csr_wdata,
   output logic                    rsp_strobe,
   output logic signed [VAL_W-1:0] rsp_actual_et,
   output logic [MM_W-1:0]         rsp_new_moisture,
   output logic signed [VAL_W-1:0] rsp_moisture_change
);

   logic [ALPHA_W-1:0] alpha_ff;
   logic               accept, push, empty, full;
   cell_type           front_cell, head_cell;

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= ALPHA_RESET;
      end else if (csr_we) begin
         alpha_ff <= csr_wdata;
      end
   end

   assign busy   = full;
   assign accept = start && !busy;

   smb_front u_front (
      .clock              (clock),
      .reset              (reset),
      .accept             (accept),
      .precipitation      (req_precipitation),
      .potential_et       (req_potential_et),
      .snow_pack_change   (req_snow_pack_change),
      .snow_pack          (req_snow_pack),
      .interception       (req_interception),
      .stored_moisture    (req_stored_moisture),
      .water_capacity     (req_water_capacity),
      .irrigated_fraction (req_irrigated_fraction),
      .push               (push),
      .grid               (front_cell)
   );

   smb_fifo #(.W($bits(cell_type)), .DEPTH(2)) u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .wdata (front_cell),
      .pop   (!empty),
      .rdata (head_cell),
      .empty (empty),
      .full  (full)
   );

   smb_back u_back (
      .clock               (clock),
      .reset               (reset),
      .alpha               (alpha_ff),
      .pop                 (!empty),
      .grid                (head_cell),
      .rsp_strobe          (rsp_strobe),
      .rsp_actual_et       (rsp_actual_et),
      .rsp_new_moisture    (rsp_new_moisture),
      .rsp_moisture_change (rsp_moisture_change)
   );

endmodule
